// ===== hdl/seven_segment_scan_driver_core_assert.svh =====
// ----------------------------------------------------------------------------
// Seven-segment scan driver assertion macros
// Concurrent checks, removed when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_CORE_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_CORE_ASSERT_SVH

`ifndef SYNTH
`define SSD_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed: label");
`define SSD_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed: label");
`else
`define SSD_ASSERT_IMPLIES(label, clk, rst, cond, expr)
`define SSD_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif

`endif

// ===== hdl/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// Seven-segment scan driver package
// Widths, limits and lookup functions shared by the driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int DIGITS  = 4;
  localparam int IDX_W   = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int CNT_W   = $clog2(DIGITS + 1);
  localparam int VALUE_W = 16;
  localparam int DIGIT_W = 4;
  localparam int SEG_W   = 8;
  localparam int POS_W   = 2;
  localparam int PACE_W  = 4;
  localparam int DATA_IN_W  = 16;
  localparam int DATA_OUT_W = 16;

  localparam logic [PACE_W-1:0] PACE_LAST = PACE_W'(10);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  function automatic logic [31:0] pow10(input int n);
    logic [31:0] p;
    p = 32'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 32'd10;
    end
    return p;
  endfunction

  localparam logic [31:0] SAT_LIMIT = pow10(DIGITS) - 32'd1;

  function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/seven_segment_scan_driver_core.sv =====
// ----------------------------------------------------------------------------
// Seven-segment scan driver core
// Converts a loaded value to decimal digits and scans them out one per tick, with a periodic blank tick.
// ----------------------------------------------------------------------------
// Channel   Group            Payload
// input     s_axis_t*        tuser[0] = opcode, tdata[15:0] = value
// output    m_axis_t*        tuser[0] = lit, tdata[1:0] = digit_position,
//                            tdata[9:2] = segments
//
// A tick's result sits in the output register.
// A load is converted by the single subtract-and-compare unit, which peels one power
// of ten a cycle off the remainder and stores each digit when the next would not fit.
// Input is held off during conversion and while an unaccepted result waits.
// Reset clears the digits to zero and the digit count to one.
// ----------------------------------------------------------------------------
`include "seven_segment_scan_driver_core_assert.svh"

module seven_segment_scan_driver_core
  import ssd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [DATA_IN_W-1:0]  s_axis_tdata,   // [15:0] value
  input  logic                  s_axis_tuser,   // [0] opcode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [DATA_OUT_W-1:0] m_axis_tdata,   // [1:0] digit_position, [9:2] segments
  output logic                  m_axis_tuser    // [0] lit
);

  typedef enum logic {
    IDLE,
    CONV
  } state_t;

  state_t              state;
  logic [DIGIT_W-1:0]  digit_store [DIGITS];
  logic [CNT_W-1:0]    digit_count;
  logic [IDX_W-1:0]    scan_index;
  logic [PACE_W-1:0]   pace_count;
  logic                skip_next;

  logic [VALUE_W-1:0]  rem;
  logic [IDX_W-1:0]    conv_k;
  logic [DIGIT_W-1:0]  conv_digit;
  logic [CNT_W-1:0]    conv_count;

  logic [31:0]         pow_tab [DIGITS];
  logic [31:0]         pow_cur;
  logic                sub_ok;
  logic [VALUE_W-1:0]  rem_next;
  logic [CNT_W-1:0]    k_plus1;

  logic                in_fire;
  logic [IDX_W-1:0]    idx;
  logic [CNT_W-1:0]    idx_plus1;
  logic [IDX_W-1:0]    scan_index_next;
  logic [VALUE_W-1:0]  value_sat;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      pow_tab[i] = pow10(i);
    end
  end

  assign pow_cur   = pow_tab[conv_k];
  assign sub_ok    = {{(32-VALUE_W){1'b0}}, rem} >= pow_cur;
  assign rem_next  = VALUE_W'({{(32-VALUE_W){1'b0}}, rem} - pow_cur);
  assign k_plus1   = CNT_W'(conv_k) + CNT_W'(1);
  assign value_sat = ({{(32-VALUE_W){1'b0}}, s_axis_tdata} > SAT_LIMIT) ?
                     SAT_LIMIT[VALUE_W-1:0] : s_axis_tdata;

  assign s_axis_tready = (state == IDLE) && (!m_axis_tvalid || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign idx             = (CNT_W'(scan_index) >= digit_count) ? '0 : scan_index;
  assign idx_plus1       = CNT_W'(idx) + CNT_W'(1);
  assign scan_index_next = (idx_plus1 >= digit_count) ? '0 : IDX_W'(idx_plus1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      digit_count   <= CNT_W'(1);
      scan_index    <= '0;
      pace_count    <= '0;
      skip_next     <= 1'b0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < DIGITS; i++) begin
        digit_store[i] <= '0;
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready && !(in_fire && s_axis_tuser == OP_TICK)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_fire) begin
            if (s_axis_tuser == OP_LOAD) begin
              rem        <= value_sat;
              conv_k     <= IDX_W'(DIGITS - 1);
              conv_digit <= '0;
              conv_count <= CNT_W'(1);
              state      <= CONV;
            end else begin
              m_axis_tvalid <= 1'b1;
              if (skip_next) begin
                skip_next    <= 1'b0;
                m_axis_tuser <= 1'b0;
                m_axis_tdata <= '0;
              end else begin
                m_axis_tuser <= 1'b1;
                m_axis_tdata <= DATA_OUT_W'({seg_of(digit_store[idx]), POS_W'(idx)});
                scan_index   <= scan_index_next;
                if (pace_count > PACE_LAST) begin
                  skip_next  <= 1'b1;
                  pace_count <= PACE_W'(1);
                end else begin
                  pace_count <= pace_count + PACE_W'(1);
                end
              end
            end
          end
        end
        CONV: begin
          if (sub_ok) begin
            rem        <= rem_next;
            conv_digit <= conv_digit + DIGIT_W'(1);
          end else begin
            digit_store[conv_k] <= conv_digit;
            conv_digit          <= '0;
            if (conv_digit != '0 && k_plus1 > conv_count) begin
              conv_count <= k_plus1;
            end
            if (conv_k == '0) begin
              digit_count <= (conv_digit != '0 && k_plus1 > conv_count) ?
                             k_plus1 : conv_count;
              state       <= IDLE;
            end else begin
              conv_k <= conv_k - IDX_W'(1);
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `SSD_ASSERT_IMPLIES(a_busy_no_ready, clk, rst, state == CONV, !s_axis_tready)
  `SSD_ASSERT_IMPLIES(a_count_range, clk, rst, 1'b1,
                      digit_count != '0 && CNT_W'(DIGITS) >= digit_count)
  `SSD_ASSERT_IMPLIES(a_dark_blank, clk, rst, m_axis_tvalid && !m_axis_tuser,
                      m_axis_tdata == '0)
  `SSD_ASSERT_NEXT(a_load_starts_conv, clk, rst, in_fire && s_axis_tuser == OP_LOAD,
                   state == CONV)

endmodule
